// ===== src/ppp_pkg.sv =====
`timescale 1ns / 1ps
package ppp_pkg;

  localparam int unsigned MaxSamples = 256;
  localparam logic [61:0] Seg2Min = 62'd2;
  localparam logic [31:0] DistMax = 32'hFFFF_FFFF;
  localparam logic [16:0] TOne = 17'h1_0000;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpAppend = 2'd1,
    OpQuery  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic [31:0]        arc_tag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] along_path;
    logic [31:0] offset_distance;
    logic        no_segment;
  } out_item_t;

  // floor of a Q.16 value / 4
  function automatic logic signed [29:0] to_q14(input logic [31:0] raw);
    return signed'(raw[31:2]);
  endfunction

  // magnitude of a 2^-30 residual rounded half up to Q.14
  function automatic logic [31:0] round_mag(input logic signed [48:0] e);
    logic [49:0] m;
    m = e[48] ? 50'(-e) : 50'(e);
    m = m + 50'd32768;
    return m[47:16];
  endfunction

endpackage

// ===== src/ppp_if.sv =====
`timescale 1ns / 1ps
interface ppp_in_if;
  import ppp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppp_out_if;
  import ppp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/ppp_ram.sv =====
`timescale 1ns / 1ps
module ppp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/point_to_polyline_projection.sv =====
`timescale 1ns / 1ps
// Nearest-point search of a query point against a stored XZ polyline. Clear and append
// transactions complete in the idle state. A query against fewer than two vertices goes
// straight to the done state; otherwise each segment is visited in turn, and the divider
// runs only for segments whose projection falls strictly inside the segment. The work is
// done by one shared 34x34 multiplier used nine times per segment, one vertex read per
// segment from the coordinate memories, a one-bit-per-cycle divider for the segment
// parameter and a 32-step square root at the end. A finished result waits in the output
// register while new transactions are taken.
module point_to_polyline_projection
  import ppp_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MaxSamples
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppp_in_if.sink    in_i,
  ppp_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StLoadA = 8'b0000_0010,
    StLatch = 8'b0000_0100,
    StSeg   = 8'b0000_1000,
    StDiv   = 8'b0001_0000,
    StSqi   = 8'b0010_0000,
    StSqrt  = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, idx_q;
  logic [3:0]    step_q, kcnt_q;
  logic [4:0]    sq_cnt_q;
  logic          short_q, found_q, sat_q;
  logic          out_valid_q;
  out_item_t     out_q;

  logic [31:0] a_x_q, a_z_q, a_arc_q, b_x_q, b_z_q, b_arc_q, p_x_q, p_z_q;
  logic [61:0] seg2_q, rem_q;
  logic signed [62:0] dot_q;
  logic [16:0] t_q;
  logic [31:0] ex_q, ez_q, best_along_q;
  logic [63:0] d2_q, best_d2_q, sv_q, sres_q, sbit_q;
  logic signed [67:0] prod_q;

  logic [31:0] rd_x, rd_z, rd_arc;
  logic        we, re;
  logic [AW-1:0] raddr;

  logic signed [30:0] abx, abz, wx, wz;
  logic signed [32:0] da;
  logic signed [33:0] mul_a, mul_b;
  logic signed [62:0] dot_sum;
  logic [62:0] rem2;
  logic [48:0] along_acc;
  logic [63:0] d2_sum, sq_try;
  logic [CW:0] next2;

  logic in_fire, out_free;
  in_item_t in_d;

  assign in_d     = in_i.data;
  assign in_i.ready = (state_q == StIdle);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign we = in_fire && (in_d.operation == OpAppend) && (count_q < CW'(MAX_SAMPLES));
  assign next2 = {1'b0, idx_q} + (CW+1)'(2);

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (state_q == StLoadA) begin
      re = 1'b1;
    end else if (state_q == StLatch) begin
      re    = 1'b1;
      raddr = AW'(idx_q + CW'(1));
    end else if (state_q == StSeg && step_q == 4'd11) begin
      re    = 1'b1;
      raddr = next2[AW-1:0];
    end
  end

  ppp_ram #(.Width(32), .Depth(MAX_SAMPLES)) u_ram_x (
    .clk_i, .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(in_d.pos_x),
    .re_i(re), .raddr_i(raddr), .rdata_o(rd_x)
  );
  ppp_ram #(.Width(32), .Depth(MAX_SAMPLES)) u_ram_z (
    .clk_i, .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(in_d.pos_z),
    .re_i(re), .raddr_i(raddr), .rdata_o(rd_z)
  );
  ppp_ram #(.Width(32), .Depth(MAX_SAMPLES)) u_ram_arc (
    .clk_i, .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(in_d.arc_tag),
    .re_i(re), .raddr_i(raddr), .rdata_o(rd_arc)
  );

  // segment geometry in Q.14
  assign abx = 31'(to_q14(b_x_q)) - 31'(to_q14(a_x_q));
  assign abz = 31'(to_q14(b_z_q)) - 31'(to_q14(a_z_q));
  assign wx  = 31'(to_q14(p_x_q)) - 31'(to_q14(a_x_q));
  assign wz  = 31'(to_q14(p_z_q)) - 31'(to_q14(a_z_q));
  assign da  = signed'({1'b0, b_arc_q}) - signed'({1'b0, a_arc_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      4'd1: begin mul_a = 34'(abx); mul_b = 34'(abx); end
      4'd2: begin mul_a = 34'(abz); mul_b = 34'(abz); end
      4'd3: begin mul_a = 34'(wx); mul_b = 34'(abx); end
      4'd4: begin mul_a = 34'(wz); mul_b = 34'(abz); end
      4'd6: begin mul_a = 34'(abx); mul_b = signed'({17'd0, t_q}); end
      4'd7: begin mul_a = 34'(abz); mul_b = signed'({17'd0, t_q}); end
      4'd8: begin mul_a = signed'({2'd0, ex_q}); mul_b = signed'({2'd0, ex_q}); end
      4'd9: begin mul_a = signed'({2'd0, ez_q}); mul_b = signed'({2'd0, ez_q}); end
      4'd10: begin mul_a = 34'(da); mul_b = signed'({17'd0, t_q}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign dot_sum   = dot_q + prod_q[62:0];
  assign rem2      = {rem_q, 1'b0};
  assign d2_sum    = d2_q + prod_q[63:0];
  assign along_acc = {1'b0, a_arc_q, 16'd0} + prod_q[48:0] + 49'd32768;
  assign sq_try    = sres_q + sbit_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire && in_d.operation == OpQuery) begin
          state_d = (count_q < CW'(2)) ? StDone : StLoadA;
        end
      end
      StLoadA: state_d = StLatch;
      StLatch: state_d = StSeg;
      StSeg: begin
        if (step_q == 4'd5 && seg2_q > Seg2Min && dot_sum > 0
            && 63'(dot_sum) < {1'b0, seg2_q}) begin
          state_d = StDiv;
        end else if (step_q == 4'd11 && next2 >= {1'b0, count_q}) begin
          state_d = StSqi;
        end
      end
      StDiv: if (kcnt_q == 4'd15) state_d = StSeg;
      StSqi: state_d = StSqrt;
      StSqrt: if (sq_cnt_q == 5'd31) state_d = StDone;
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      kcnt_q      <= '0;
      sq_cnt_q    <= '0;
      short_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (in_d.operation == OpClear) count_q <= '0;
            if (we) count_q <= count_q + CW'(1);
            short_q <= (count_q < CW'(2));
            found_q <= 1'b0;
            idx_q   <= '0;
          end
        end
        StLatch: step_q <= '0;
        StSeg: begin
          if (step_q == 4'd5 && state_d == StDiv) begin
            kcnt_q <= '0;
            step_q <= 4'd6;
          end else if (step_q == 4'd11) begin
            found_q <= 1'b1;
            idx_q   <= idx_q + CW'(1);
            step_q  <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        StDiv: kcnt_q <= kcnt_q + 4'd1;
        StSqi: sq_cnt_q <= '0;
        StSqrt: sq_cnt_q <= sq_cnt_q + 5'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire) begin
      p_x_q <= in_d.pos_x;
      p_z_q <= in_d.pos_z;
    end
    case (state_q)
      StLatch: begin
        a_x_q   <= rd_x;
        a_z_q   <= rd_z;
        a_arc_q <= rd_arc;
      end
      StSeg: begin
        case (step_q)
          4'd0: begin
            b_x_q   <= rd_x;
            b_z_q   <= rd_z;
            b_arc_q <= rd_arc;
          end
          4'd2: seg2_q <= prod_q[61:0];
          4'd3: seg2_q <= seg2_q + prod_q[61:0];
          4'd4: dot_q <= prod_q[62:0];
          4'd5: begin
            dot_q <= dot_sum;
            rem_q <= 62'(dot_sum);
            if (seg2_q > Seg2Min && dot_sum > 0 && 63'(dot_sum) >= {1'b0, seg2_q}) begin
              t_q <= TOne;
            end else begin
              t_q <= '0;
            end
          end
          4'd7: ex_q <= round_mag(({{2{wx[30]}}, wx, 16'd0}) - prod_q[48:0]);
          4'd8: ez_q <= round_mag(({{2{wz[30]}}, wz, 16'd0}) - prod_q[48:0]);
          4'd9: d2_q <= prod_q[63:0];
          4'd10: d2_q <= d2_sum;
          4'd11: begin
            if (!found_q || d2_q < best_d2_q) begin
              best_d2_q    <= d2_q;
              best_along_q <= along_acc[47:16];
            end
            a_x_q   <= b_x_q;
            a_z_q   <= b_z_q;
            a_arc_q <= b_arc_q;
          end
          default: ;
        endcase
      end
      StDiv: begin
        if (rem2 >= {1'b0, seg2_q}) begin
          rem_q <= 62'(rem2 - {1'b0, seg2_q});
          t_q   <= {t_q[15:0], 1'b1};
        end else begin
          rem_q <= rem2[61:0];
          t_q   <= {t_q[15:0], 1'b0};
        end
      end
      StSqi: begin
        sat_q  <= (best_d2_q[63:60] != 4'd0);
        sv_q   <= {best_d2_q[59:0], 4'd0};
        sres_q <= '0;
        sbit_q <= 64'd1 << 62;
      end
      StSqrt: begin
        if (sv_q >= sq_try) begin
          sv_q   <= sv_q - sq_try;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      StDone: begin
        if (out_free) begin
          if (short_q) begin
            out_q.along_path      <= '0;
            out_q.offset_distance <= DistMax;
            out_q.no_segment      <= 1'b1;
          end else begin
            out_q.along_path      <= best_along_q;
            out_q.offset_distance <= sat_q ? DistMax : sres_q[31:0];
            out_q.no_segment      <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SAMPLES))
    else $error("vertex count beyond capacity");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> rem_q < seg2_q)
    else $error("divider remainder not below divisor");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSeg && step_q == 4'd6) |-> t_q <= TOne)
    else $error("segment parameter out of range");

  a_short_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.no_segment) |-> out_q.along_path == '0)
    else $error("no-segment result carries an arc position");

endmodule
